>>> rtl/quadrature_tempo_knob_macros.svh
// assertion helpers for the tempo knob
`ifndef QUADRATURE_TEMPO_KNOB_MACROS_SVH
`define QUADRATURE_TEMPO_KNOB_MACROS_SVH

// same-cycle implication, checked outside reset
`define QTK_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qtk same-cycle check failed");

// next-cycle implication, checked outside reset
`define QTK_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qtk next-cycle check failed");

`endif

>>> rtl/qtk_pkg.sv
`default_nettype none

package qtk_pkg;

	localparam int DIVIDEND_W = 20;
	localparam int TEMPO_W    = 8;
	localparam int RELOAD_W   = 16;
	localparam int BAND_W     = 10;

	localparam logic [DIVIDEND_W-1:0] DIVIDEND_RESET = 20'd600000;
	localparam logic [TEMPO_W-1:0]    TEMPO_RESET    = 8'd60;

	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_CW   = 2'b01;
	localparam logic [1:0] DIR_CCW  = 2'b11;

	localparam logic [1:0] PHASE_DETENT = 2'b00;

	// band edges on the stepped tempo
	localparam logic signed [BAND_W-1:0] BAND_LO   = 10'sd30;
	localparam logic signed [BAND_W-1:0] BAND_2X   = 10'sd60;
	localparam logic signed [BAND_W-1:0] BAND_3X   = 10'sd72;
	localparam logic signed [BAND_W-1:0] BAND_5X   = 10'sd120;
	localparam logic signed [BAND_W-1:0] BAND_7X   = 10'sd144;
	localparam logic signed [BAND_W-1:0] BAND_HI   = 10'sd208;

	typedef struct packed {
		logic [1:0]         dir;
		logic [TEMPO_W-1:0] tempo;
		logic               update;
	} step_info_t;

	function automatic logic [1:0] cw_next(input logic [1:0] ph);
		logic [1:0] r;
		unique case (ph)
			2'd0: r = 2'd2;
			2'd1: r = 2'd0;
			2'd2: r = 2'd3;
			default: r = 2'd1;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] ccw_next(input logic [1:0] ph);
		logic [1:0] r;
		unique case (ph)
			2'd0: r = 2'd1;
			2'd1: r = 2'd3;
			2'd2: r = 2'd0;
			default: r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] band_mult(input logic signed [BAND_W-1:0] n);
		logic [2:0] m;
		if (n >= BAND_LO && n < BAND_2X) m = 3'd1;
		else if (n >= BAND_2X && n < BAND_3X) m = 3'd2;
		else if (n >= BAND_3X && n < BAND_5X) m = 3'd3;
		else if (n >= BAND_5X && n < BAND_7X) m = 3'd5;
		else if (n >= BAND_7X && n < BAND_HI) m = 3'd7;
		else m = 3'd0;
		return m;
	endfunction

endpackage

`default_nettype wire

>>> rtl/quadrature_tempo_knob.sv
// quadrature tempo knob
// input channel: one transaction per encoder pin change, carrying pin_a and
// pin_b (in_valid / in_stall). the first transaction after reset only primes
// the stored phase. output channel: exactly one transaction per input, with
// step_direction, tempo_now, reload_update and reload_value
// (out_valid / out_stall).
// a sample that does not land on the detent moves from the result registers
// into the output register once it is free or being emptied. a detent sample
// moves the tempo by band and runs a bit-serial 20 by 8 bit divider, one
// quotient bit per cycle, before its result moves on; the next sample is
// taken only after that, so the divider sets the throughput at detent.
// one sample is worked on at a time; in_stall stays high from acceptance
// until the result has moved into the output register.
// the output register holds one finished transaction, so a new sample can be
// taken while the receiver stalls; a second result then waits inside.
// period_dividend is written over the apb port at addresses 0 to 3; the user
// must write it only while idle, the block itself does not enforce this.
// reset: tempo 60, dividend 600000, encoder unprimed, output empty.

`default_nettype none

module quadrature_tempo_knob (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// sample channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        pin_a,
	input  wire logic        pin_b,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic signed [1:0] step_direction,
	output logic [7:0]       tempo_now,
	output logic             reload_update,
	output logic [15:0]      reload_value,
	// register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [qtk_pkg::DIVIDEND_W-1:0] period_dividend_q;

	// result of the sample in flight
	logic [1:0]                  res_dir_q;
	logic [qtk_pkg::TEMPO_W-1:0] res_tempo_q;
	logic                        res_update_q;

	logic                        out_valid_q;
	logic [1:0]                  out_dir_q;
	logic [qtk_pkg::TEMPO_W-1:0] out_tempo_q;
	logic                        out_update_q;
	logic [qtk_pkg::RELOAD_W-1:0] out_reload_q;

	qtk_pkg::step_info_t info;

	logic                           in_accept;
	logic                           div_start;
	logic                           div_done;
	logic [qtk_pkg::DIVIDEND_W-1:0] quotient;
	logic [qtk_pkg::DIVIDEND_W-1:0] q_minus;
	logic [qtk_pkg::RELOAD_W-1:0]   reload;
	logic                           out_free;
	logic                           cfg_write;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign div_start = in_accept && info.update;
	assign out_free  = !out_valid_q || !out_stall;

	// phase classification and tempo bands, state kept inside
	qtk_tempo u_tempo (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (in_accept),
		.pin_a  (pin_a),
		.pin_b  (pin_b),
		.info   (info)
	);

	// beat period: dividend over the new tempo
	qtk_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (period_dividend_q),
		.divisor  (info.tempo),
		.done     (div_done),
		.quotient (quotient)
	);

	// quotient minus one, saturated to 16 bits; no update, zero quotient or zero tempo gives zero
	always_comb begin
		q_minus = quotient - qtk_pkg::DIVIDEND_W'(1);
		if (!res_update_q || quotient == '0 || res_tempo_q == '0)
			reload = '0;
		else if (q_minus[qtk_pkg::DIVIDEND_W-1:qtk_pkg::RELOAD_W] != '0)
			reload = '1;
		else
			reload = q_minus[qtk_pkg::RELOAD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			res_dir_q    <= qtk_pkg::DIR_NONE;
			res_tempo_q  <= qtk_pkg::TEMPO_RESET;
			res_update_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_dir_q    <= qtk_pkg::DIR_NONE;
			out_tempo_q  <= qtk_pkg::TEMPO_RESET;
			out_update_q <= 1'b0;
			out_reload_q <= '0;
		end else begin
			// emptied unless refilled from the done state below
			if (out_valid_q && !out_stall && state_q != ST_DONE) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						res_dir_q    <= info.dir;
						res_tempo_q  <= info.tempo;
						res_update_q <= info.update;
						state_q      <= info.update ? ST_DIVIDE : ST_DONE;
					end
				end
				ST_DIVIDE: begin
					if (div_done) state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hand over once the output register is free or being emptied
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_dir_q    <= res_dir_q;
						out_tempo_q  <= res_tempo_q;
						out_update_q <= res_update_q;
						out_reload_q <= reload;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign step_direction = $signed(out_dir_q);
	assign tempo_now      = out_tempo_q;
	assign reload_update  = out_update_q;
	assign reload_value   = out_reload_q;

	// register port, single register at word 0
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_dividend_q <= qtk_pkg::DIVIDEND_RESET;
		end else if (cfg_write) begin
			period_dividend_q <= pwdata[qtk_pkg::DIVIDEND_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == 1'b0) prdata = {{(32-qtk_pkg::DIVIDEND_W){1'b0}}, period_dividend_q};
		else prdata = '0;
	end

	`include "quadrature_tempo_knob_macros.svh"

	// no reload value without an update
	`QTK_ASSERT_IMPLY(a_reload_zero, out_valid_q && !out_update_q, out_reload_q == '0)
	// an accepted sample always keeps the input busy for the next cycle
	`QTK_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall)
	// tempo never leaves the reachable range
	`QTK_ASSERT_IMPLY(a_tempo_range, out_valid_q, out_tempo_q >= 8'd29 && out_tempo_q <= 8'd214)

endmodule

`default_nettype wire

>>> rtl/qtk_tempo.sv
`default_nettype none

module qtk_tempo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic               pin_a,
	input  wire logic               pin_b,
	output qtk_pkg::step_info_t     info
);

	logic [1:0]                  last_phase_q;
	logic                        primed_q;
	logic [qtk_pkg::TEMPO_W-1:0] tempo_q;

	logic [1:0]                          phase;
	logic [1:0]                          dir;
	logic                                detent;
	logic signed [qtk_pkg::BAND_W-1:0]   n;
	logic [2:0]                          m;
	logic [qtk_pkg::TEMPO_W-1:0]         tempo_new;

	always_comb begin
		phase = {pin_a, pin_b};
		if (!primed_q) dir = qtk_pkg::DIR_NONE;
		else if (qtk_pkg::cw_next(last_phase_q) == phase) dir = qtk_pkg::DIR_CW;
		else if (qtk_pkg::ccw_next(last_phase_q) == phase) dir = qtk_pkg::DIR_CCW;
		else dir = qtk_pkg::DIR_NONE;

		detent = primed_q && (phase == qtk_pkg::PHASE_DETENT);
		n = $signed({2'b00, tempo_q}) +
			$signed({{(qtk_pkg::BAND_W-2){dir[1]}}, dir});
		m = qtk_pkg::band_mult(n);

		tempo_new = tempo_q;
		if (detent && m != 3'd0) begin
			case (dir)
				qtk_pkg::DIR_CW:  tempo_new = n[qtk_pkg::TEMPO_W-1:0] + {5'd0, m};
				qtk_pkg::DIR_CCW: tempo_new = n[qtk_pkg::TEMPO_W-1:0] - {5'd0, m};
				default:          tempo_new = n[qtk_pkg::TEMPO_W-1:0];
			endcase
		end

		info.dir    = dir;
		info.tempo  = tempo_new;
		info.update = detent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_phase_q <= 2'b00;
			primed_q     <= 1'b0;
			tempo_q      <= qtk_pkg::TEMPO_RESET;
		end else if (accept) begin
			last_phase_q <= phase;
			primed_q     <= 1'b1;
			tempo_q      <= tempo_new;
		end
	end

endmodule

`default_nettype wire

>>> rtl/qtk_div.sv
`default_nettype none

module qtk_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [qtk_pkg::DIVIDEND_W-1:0] dividend,
	input  wire logic [qtk_pkg::TEMPO_W-1:0]    divisor,
	output logic                                done,
	output logic [qtk_pkg::DIVIDEND_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(qtk_pkg::DIVIDEND_W + 1);

	logic                              busy_q;
	logic                              done_q;
	logic [CNT_W-1:0]                  count_q;
	logic [qtk_pkg::DIVIDEND_W-1:0]    acc_q;
	logic [qtk_pkg::TEMPO_W-1:0]       rem_q;
	logic [qtk_pkg::TEMPO_W-1:0]       divisor_q;

	logic [qtk_pkg::TEMPO_W:0] trial;
	logic [qtk_pkg::TEMPO_W:0] diff;
	logic                      ge;

	// one quotient bit per cycle, dividend shifts out as quotient shifts in
	always_comb begin
		trial = {rem_q, acc_q[qtk_pkg::DIVIDEND_W-1]};
		diff  = trial - {1'b0, divisor_q};
		ge    = trial >= {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			count_q   <= '0;
			acc_q     <= '0;
			rem_q     <= '0;
			divisor_q <= '0;
		end else begin
			// pulse after the last quotient bit
			done_q <= !start && busy_q && (count_q == CNT_W'(1));
			if (start) begin
				busy_q    <= 1'b1;
				count_q   <= CNT_W'(qtk_pkg::DIVIDEND_W);
				acc_q     <= dividend;
				rem_q     <= '0;
				divisor_q <= divisor;
			end else if (busy_q) begin
				acc_q   <= {acc_q[qtk_pkg::DIVIDEND_W-2:0], ge};
				rem_q   <= ge ? diff[qtk_pkg::TEMPO_W-1:0] : trial[qtk_pkg::TEMPO_W-1:0];
				count_q <= count_q - CNT_W'(1);
				if (count_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = acc_q;

endmodule

`default_nettype wire

>>> sim/quadrature_tempo_knob_tb.sv
`default_nettype none

module quadrature_tempo_knob_tb;

	localparam int CLK_PERIOD = 8;
	localparam int RESET_CYCLES = 7;
	// outlasts a detent transaction through the divider, so this covers any work still in flight
	localparam int DRAIN_CYCLES = 40;
	localparam int WATCHDOG_CYCLES = 1_000_000;
	localparam int MAX_REPORTS = 10;

	// register map: period_dividend at byte address 0 (0 to 3 decode to it); 4 to 7 are unmapped
	localparam logic [2:0] DIVIDEND_ADDR = 3'd0;
	localparam logic [2:0] UNMAPPED_ADDR = 3'd4;

	// next phase for one clockwise / counter-clockwise step, indexed by the current phase
	localparam logic [7:0] CW_STEP  = {2'd1, 2'd3, 2'd0, 2'd2};
	localparam logic [7:0] CCW_STEP = {2'd2, 2'd0, 2'd3, 2'd1};

	typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;

	typedef struct packed {
		logic signed [1:0] dir;
		logic [7:0]        tempo;
		logic              update;
		logic [15:0]       reload;
	} knob_result_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// sample channel
	logic in_valid = 1'b0;
	logic in_stall;
	logic pin_a = 1'b0;
	logic pin_b = 1'b0;

	// result channel
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic signed [1:0] step_direction;
	logic [7:0]        tempo_now;
	logic              reload_update;
	logic [15:0]       reload_value;

	// register port
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	always #(CLK_PERIOD / 2) clk = ~clk;

	quadrature_tempo_knob DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pin_a          (pin_a),
		.pin_b          (pin_b),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.step_direction (step_direction),
		.tempo_now      (tempo_now),
		.reload_update  (reload_update),
		.reload_value   (reload_value),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	// pin samples waiting to be offered, as {pin_a, pin_b}
	logic [1:0] pending_samples[$];
	// results the knob owes us, oldest first
	knob_result_t owed_results[$];

	// mirror of the knob's state
	logic [1:0]  knob_phase = qtk_pkg::PHASE_DETENT;
	logic        knob_primed = 1'b0;
	logic [7:0]  knob_tempo = qtk_pkg::TEMPO_RESET;
	logic [19:0] knob_dividend = qtk_pkg::DIVIDEND_RESET;

	// phase the stimulus generator last queued
	logic [1:0] gen_phase = qtk_pkg::PHASE_DETENT;

	int send_gap_pct = 0;
	int recv_stall_pct = 0;

	int samples_queued = 0;
	int samples_taken = 0;
	int results_seen = 0;
	int mismatches = 0;
	int cw_steps = 0;
	int ccw_steps = 0;
	int detent_updates = 0;
	int reg_writes = 0;
	int tempo_lo = 255;
	int tempo_hi = 0;

	logic [1:0] next_sample;
	knob_result_t owed;

	// one sample against the mirrored state: classify, move the tempo at the detent,
	// and work out the timer reload
	function automatic knob_result_t knob_advance(input logic [1:0] phase);
		knob_result_t r;
		int step;
		int n;
		int mult;
		int quot;
		r = '0;
		r.dir = qtk_pkg::DIR_NONE;
		if (!knob_primed) begin
			// priming transaction: just remember where the knob sits
			knob_primed = 1'b1;
			knob_phase = phase;
		end else begin
			step = 0;
			if (phase == CW_STEP[knob_phase*2 +: 2]) begin
				r.dir = qtk_pkg::DIR_CW;
				step = 1;
			end else if (phase == CCW_STEP[knob_phase*2 +: 2]) begin
				r.dir = qtk_pkg::DIR_CCW;
				step = -1;
			end
			if (phase == qtk_pkg::PHASE_DETENT) begin
				// noise at the detent still updates, with a step of zero
				n = int'(knob_tempo) + step;
				if (n >= qtk_pkg::BAND_LO && n < qtk_pkg::BAND_2X) mult = 1;
				else if (n >= qtk_pkg::BAND_2X && n < qtk_pkg::BAND_3X) mult = 2;
				else if (n >= qtk_pkg::BAND_3X && n < qtk_pkg::BAND_5X) mult = 3;
				else if (n >= qtk_pkg::BAND_5X && n < qtk_pkg::BAND_7X) mult = 5;
				else if (n >= qtk_pkg::BAND_7X && n < qtk_pkg::BAND_HI) mult = 7;
				else mult = 0;
				if (mult != 0) knob_tempo = 8'(n + mult * step);
				r.update = 1'b1;
				// a dividend below the tempo gives a quotient of zero, reload pinned at zero
				quot = (knob_tempo == 0) ? 0 : int'(knob_dividend / knob_tempo);
				if (quot == 0) r.reload = '0;
				else if (quot - 1 > 65535) r.reload = 16'hFFFF;
				else r.reload = 16'(quot - 1);
			end
			knob_phase = phase;
		end
		r.tempo = knob_tempo;
		return r;
	endfunction

	task automatic queue_phase(input logic [1:0] phase);
		pending_samples.push_back(phase);
		gen_phase = phase;
		samples_queued++;
	endtask

	task automatic queue_steps(input bit clockwise, input int steps);
		repeat (steps) begin
			if (clockwise) queue_phase(CW_STEP[gen_phase*2 +: 2]);
			else queue_phase(CCW_STEP[gen_phase*2 +: 2]);
		end
	endtask

	// keep turning until the knob has clicked into the detent the given number of times
	task automatic queue_turn(input bit clockwise, input int detents);
		int clicks;
		clicks = 0;
		while (clicks < detents) begin
			queue_steps(clockwise, 1);
			if (gen_phase == qtk_pkg::PHASE_DETENT) clicks++;
		end
	endtask

	// mostly clean turns in runs that tend to keep their direction, so the tempo
	// sweeps across every band; the rest is jitter and pin noise
	task automatic queue_random_turning(input int count);
		int goal;
		int pick;
		bit clockwise;
		goal = samples_queued + count;
		clockwise = $urandom_range(0, 1);
		while (samples_queued < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				if ($urandom_range(0, 99) < 30) clockwise = !clockwise;
				queue_turn(clockwise, $urandom_range(1, 10));
			end else if (pick < 85) begin
				// contact bounce: a few steps one way and back
				queue_steps(clockwise, $urandom_range(1, 3));
				queue_steps(!clockwise, $urandom_range(1, 3));
			end else begin
				queue_phase(2'($urandom_range(0, 3)));
			end
		end
	endtask

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_FULL: begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			PACE_SEND_GAPS: begin
				send_gap_pct = 61;
				recv_stall_pct = 0;
			end
			PACE_RECV_STALLS: begin
				send_gap_pct = 0;
				recv_stall_pct = 61;
			end
			default: begin
				send_gap_pct = 16;
				recv_stall_pct = 16;
			end
		endcase
	endtask

	// hold off until everything queued has gone through and come back, then let the
	// knob go quiet before anything else happens
	task automatic wait_for_quiet();
		do @(negedge clk);
		while (pending_samples.size() != 0 || in_valid || owed_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// apb write (setup then access), followed by a read-back of the dividend
	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		if (addr == DIVIDEND_ADDR) knob_dividend = data[19:0];
		reg_writes++;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= DIVIDEND_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		if (prdata[19:0] !== knob_dividend) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch: period_dividend read back expected %0d, got %0d",
					knob_dividend, prdata[19:0]);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic report_field(input string field, input int exp, input int act);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch at result %0d: %s expected %0d, got %0d",
				results_seen, field, exp, act);
	endtask

	// sample driver: a held transaction stays put while stalled; a gap is only
	// chosen when no transaction is held, so valid never follows stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				owed_results.push_back(knob_advance({pin_a, pin_b}));
				samples_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
					next_sample = pending_samples.pop_front();
					in_valid <= 1'b1;
					pin_a <= next_sample[1];
					pin_b <= next_sample[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: every taken transaction is checked against the oldest owed result
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (owed_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch: result %0d arrived with nothing owed (tempo %0d)",
							results_seen, tempo_now);
				end else begin
					owed = owed_results.pop_front();
					if (step_direction !== owed.dir)
						report_field("step_direction", owed.dir, step_direction);
					if (tempo_now !== owed.tempo)
						report_field("tempo_now", owed.tempo, tempo_now);
					if (reload_update !== owed.update)
						report_field("reload_update", owed.update, reload_update);
					if (reload_value !== owed.reload)
						report_field("reload_value", owed.reload, reload_value);
					if (owed.dir == qtk_pkg::DIR_CW) cw_steps++;
					if (owed.dir == qtk_pkg::DIR_CCW) ccw_steps++;
					if (owed.update) detent_updates++;
					if (owed.tempo < tempo_lo) tempo_lo = owed.tempo;
					if (owed.tempo > tempo_hi) tempo_hi = owed.tempo;
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: priming off the detent, then every kind of step the knob knows
		set_pace(PACE_FULL);
		queue_phase(2'b11);                 // priming transaction, no update
		queue_phase(qtk_pkg::PHASE_DETENT); // two-step jump onto the detent: noise, still updates
		queue_turn(1'b1, 1);                // one clean clockwise click
		queue_turn(1'b0, 1);                // and back counter-clockwise
		queue_phase(qtk_pkg::PHASE_DETENT); // same phase again at the detent
		queue_phase(2'b01);
		queue_phase(2'b10);                 // jump between opposite phases off the detent
		queue_phase(2'b10);                 // repeated phase off the detent
		queue_steps(1'b1, 3);
		queue_turn(1'b1, 2);
		queue_turn(1'b0, 2);
		wait_for_quiet();

		// a dividend below any tempo: quotient of zero
		reg_write(DIVIDEND_ADDR, 32'd1);
		set_pace(PACE_SEND_GAPS);
		queue_turn(1'b0, 12);      // push the tempo down toward the bottom edge
		queue_random_turning(140);
		wait_for_quiet();

		// largest dividend, then run the tempo up toward the top edge
		reg_write(DIVIDEND_ADDR, 32'h000F_FFFF);
		set_pace(PACE_RECV_STALLS);
		queue_turn(1'b1, 40);
		queue_random_turning(160);
		wait_for_quiet();

		// unmapped address: must leave the dividend alone
		reg_write(UNMAPPED_ADDR, 32'h0000_1234);
		set_pace(PACE_BOTH);
		queue_random_turning(200);
		wait_for_quiet();

		// upper bits of the write data fall outside the register
		reg_write(DIVIDEND_ADDR, 32'hFFF0_0E10);
		set_pace(PACE_FULL);
		queue_random_turning(200);
		wait_for_quiet();

		// dividend equal to the reset tempo: quotient of two, one or zero
		reg_write(DIVIDEND_ADDR, 32'd60);
		set_pace(PACE_SEND_GAPS);
		queue_random_turning(150);
		wait_for_quiet();

		reg_write(DIVIDEND_ADDR, 32'($urandom_range(1, 20'hFFFFF)));
		set_pace(PACE_RECV_STALLS);
		queue_random_turning(200);
		wait_for_quiet();

		reg_write(DIVIDEND_ADDR, 32'(qtk_pkg::DIVIDEND_RESET));
		set_pace(PACE_BOTH);
		queue_random_turning(200);
		wait_for_quiet();

		reg_write(DIVIDEND_ADDR, 32'($urandom_range(1, 20'hFFFFF)));
		set_pace(PACE_FULL);
		queue_random_turning(200);
		wait_for_quiet();

		$display("run: %0d samples taken, %0d results checked, %0d register writes",
			samples_taken, results_seen, reg_writes);
		$display("run: %0d cw and %0d ccw steps, %0d detent updates, tempo spanned %0d..%0d",
			cw_steps, ccw_steps, detent_updates, tempo_lo, tempo_hi);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches in total", mismatches);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// watchdog in case a handshake never completes
	initial begin
		#(CLK_PERIOD * WATCHDOG_CYCLES);
		$display("timeout: %0d samples taken, %0d results seen, %0d still owed",
			samples_taken, results_seen, owed_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
